>>> hw/rtl/jsu_pkg.sv
// Shared types and codes for the JSON string unescaper.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_BODY = 3'd1;
	localparam logic [2:0] PH_ESC  = 3'd2;
	localparam logic [2:0] PH_HEX0 = 3'd3;
	localparam logic [2:0] PH_HEX1 = 3'd4;
	localparam logic [2:0] PH_HEX2 = 3'd5;
	localparam logic [2:0] PH_HEX3 = 3'd6;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_OK   = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam int MAX_RESULTS = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       run_end;
	} result_t;

endpackage

`default_nettype wire

>>> hw/rtl/json_string_unescaper.sv
// Top level of the JSON string unescaper.
//
// Bytes of a quoted string enter on the byte channel (byte_valid, byte_stall,
// byte_data), with first marking the opening quote and last the closing one.
// Decoded bytes and the end-of-string report leave on the result channel
// (res_valid, res_stall, res_data); run_end marks the last result of a byte.
// A byte is decoded in the cycle of its transfer and its results appear in
// the result register in the cycle after. Most bytes give zero or one
// result, so one byte per cycle is sustained while res_stall is low. A \u
// escape that encodes to two or three UTF-8 bytes holds the byte channel
// while the three-entry result register drains; the input is taken again
// in the cycle its last pending result transfers.
// Reset clears the decoder to wait for an opening byte and empties the
// result register. A stall on the result side holds the current result and,
// once the pending group cannot drain, stalls the byte channel.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescaper import jsu_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    byte_valid,
	output logic         byte_stall,
	input  wire item_t   byte_data,
	output logic         res_valid,
	input  wire logic    res_stall,
	output result_t      res_data
);

	logic [2:0]  phase_q;
	logic [15:0] acc_q;
	logic        err_q;
	logic [1:0]  cnt_q;
	result_t     slot_q [MAX_RESULTS];

	logic [2:0]  nxt_phase;
	logic [15:0] nxt_acc;
	logic        nxt_err;
	logic [1:0]  n;
	result_t     r [MAX_RESULTS];
	logic        in_xfer;
	logic        out_xfer;
	logic [4:0]  hex_d;
	logic [15:0] code;
	logic [7:0]  c;

	function automatic logic [4:0] hex_value(input logic [7:0] ch);
		logic [4:0] v;
		v = 5'h10;
		if (ch >= "0" && ch <= "9") v = {1'b0, ch[3:0]};
		else if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F"))
			v = {1'b0, ch[3:0] + 4'd9};
		return v;
	endfunction

	function automatic logic [7:0] simple_escape(input logic [7:0] ch);
		logic [7:0] v;
		v = ch;
		case (ch)
			"b":     v = 8'h08;
			"f":     v = 8'h0C;
			"n":     v = 8'h0A;
			"r":     v = 8'h0D;
			"t":     v = 8'h09;
			default: v = ch;
		endcase
		return v;
	endfunction

	assign res_valid  = cnt_q != 2'd0;
	assign res_data   = slot_q[0];
	assign out_xfer   = res_valid && !res_stall;
	assign byte_stall = !(cnt_q == 2'd0 || (cnt_q == 2'd1 && !res_stall));
	assign in_xfer    = byte_valid && !byte_stall;

	assign c     = byte_data.in_byte;
	assign hex_d = hex_value(c);
	assign code  = {acc_q[11:0], hex_d[3:0]};

	always_comb begin
		nxt_phase = phase_q;
		nxt_acc   = acc_q;
		nxt_err   = err_q;
		n         = 2'd0;
		for (int i = 0; i < MAX_RESULTS; i++) r[i] = '0;
		if (byte_data.first) begin
			nxt_acc = '0;
			if (byte_data.last) begin
				nxt_phase = PH_IDLE;
				nxt_err   = 1'b0;
				r[0]      = '{out_byte: 8'h00, kind: KIND_ERR, run_end: 1'b1};
				n         = 2'd1;
			end else begin
				nxt_err   = c != "\"";
				nxt_phase = PH_BODY;
			end
		end else if (phase_q == PH_IDLE || phase_q > PH_HEX3) begin
			n = 2'd0;
		end else if (byte_data.last) begin
			r[0].kind    = (err_q || phase_q >= PH_HEX0) ? KIND_ERR : KIND_OK;
			r[0].run_end = 1'b1;
			n            = 2'd1;
			nxt_phase    = PH_IDLE;
			nxt_err      = 1'b0;
			nxt_acc      = '0;
		end else if (!err_q) begin
			if (phase_q == PH_BODY) begin
				if (c == "\\") nxt_phase = PH_ESC;
				else begin
					r[0] = '{out_byte: c, kind: KIND_DATA, run_end: 1'b1};
					n    = 2'd1;
				end
			end else if (phase_q == PH_ESC) begin
				if (c == "u") begin
					nxt_acc   = '0;
					nxt_phase = PH_HEX0;
				end else begin
					r[0]      = '{out_byte: simple_escape(c), kind: KIND_DATA, run_end: 1'b1};
					n         = 2'd1;
					nxt_phase = PH_BODY;
				end
			end else if (hex_d[4]) begin
				nxt_err   = 1'b1;
				nxt_phase = PH_BODY;
			end else begin
				nxt_acc = code;
				if (phase_q == PH_HEX3) begin
					nxt_phase = PH_BODY;
					if (code < 16'h0080) begin
						r[0] = '{out_byte: code[7:0], kind: KIND_DATA, run_end: 1'b1};
						n    = 2'd1;
					end else if (code < 16'h0800) begin
						r[0].out_byte = 8'hC0 | {3'b000, code[10:6]};
						r[1].out_byte = 8'h80 | {2'b00, code[5:0]};
						r[1].run_end  = 1'b1;
						n             = 2'd2;
					end else begin
						r[0].out_byte = 8'hE0 | {4'h0, code[15:12]};
						r[1].out_byte = 8'h80 | {2'b00, code[11:6]};
						r[2].out_byte = 8'h80 | {2'b00, code[5:0]};
						r[2].run_end  = 1'b1;
						n             = 2'd3;
					end
				end else begin
					nxt_phase = phase_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			err_q   <= 1'b0;
		end else if (in_xfer) begin
			phase_q <= nxt_phase;
			acc_q   <= nxt_acc;
			err_q   <= nxt_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (in_xfer && n != 2'd0) begin
			cnt_q <= n;
		end else if (out_xfer) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && n != 2'd0) begin
			for (int i = 0; i < MAX_RESULTS; i++) slot_q[i] <= r[i];
		end else if (out_xfer) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/jsu_checker.sv
// Port-level checks for the JSON string unescaper and their binding.
`timescale 1ns / 1ps
`default_nettype none

module jsu_checker import jsu_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    byte_valid,
	input wire logic    byte_stall,
	input wire item_t   byte_data,
	input wire logic    res_valid,
	input wire logic    res_stall,
	input wire result_t res_data
);

	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_data))
		else $error("Stalled byte transfer changed.");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("Stalled result changed.");

	a_stall_pending: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> res_valid)
		else $error("Byte channel stalled with no pending result.");

	a_end_report: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.kind != KIND_DATA |->
			res_data.run_end && res_data.out_byte == 8'h00)
		else $error("End report malformed.");

	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res_data.run_end |=> res_valid)
		else $error("Result group broken off before its last transfer.");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.byte_data  (byte_data),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_data   (res_data)
);

`default_nettype wire
